// ===== src/pwbs_pkg.sv =====
package pwbs_pkg;

  localparam int TYPE_COUNT = 1024;
  localparam logic [15:0] BUDGET_RESET = 16'd2048;
  localparam logic [16:0] HEADER_BYTES = 17'd12;

  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [9:0]  message_type;
    logic [31:0] timestamp;
    logic [15:0] payload_length;
  } pwbs_in_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] fill_after;
    logic [31:0] accepted_count;
    logic [31:0] second_count;
    logic [47:0] average_rate;
    logic        average_valid;
  } pwbs_out_t;

  typedef struct packed {
    logic [31:0] msg_cnt;
    logic [31:0] sec_cnt;
    logic [15:0] fill;
    logic [31:0] last_time;
  } pwbs_entry_t;

  localparam int ENTRY_W = $bits(pwbs_entry_t);

endpackage

// ===== src/per_type_window_budget_stats.sv =====
// channel   | ports                          | handshake
// ----------+--------------------------------+----------------------------------
// item in   | start, busy, in_item           | taken when start && !busy
// result    | done, result                   | one-cycle strobe, cannot stall
// config    | budget_we, budget_wdata        | written when budget_we high
//
// after reset a clear sweep writes every table row; busy stays high during reset
// and once the two-entry queue fills; items queue meanwhile
// an item runs from queue pop through read, update write, divider load,
// 48 divider steps and output before the next pop; the divider is
// skipped when the type has no seconds
// rst is synchronous and active high; the result side never stalls
module per_type_window_budget_stats (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pwbs_pkg::pwbs_in_t   in_item,
  output logic                 done,
  output pwbs_pkg::pwbs_out_t  result,
  input  logic                 budget_we,
  input  logic [15:0]          budget_wdata
);
  import pwbs_pkg::*;

  localparam int IDX_W = $clog2(TYPE_COUNT);

  logic [15:0]      budget;
  logic             q_valid, q_op, q_pop;
  logic [IDX_W-1:0] q_idx;
  logic [31:0]      q_time;
  logic [15:0]      q_len;

  // byte budget register
  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= BUDGET_RESET;
    end else if (budget_we) begin
      budget <= budget_wdata;
    end
  end

  pwbs_front #(.IDX_W(IDX_W)) u_front (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item), .busy(busy),
    .q_valid(q_valid), .q_op(q_op), .q_idx(q_idx), .q_time(q_time),
    .q_len(q_len), .q_pop(q_pop)
  );

  pwbs_back #(.IDX_W(IDX_W)) u_back (
    .clk(clk), .rst(rst), .budget(budget), .q_valid(q_valid), .q_op(q_op),
    .q_idx(q_idx), .q_time(q_time), .q_len(q_len), .q_pop(q_pop),
    .done(done), .result(result)
  );

endmodule

// ===== src/pwbs_ram.sv =====
module pwbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/pwbs_front.sv =====
// accepts items, reduces type to an index, holds them in a two-entry queue
module pwbs_front #(
  parameter int IDX_W = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pwbs_pkg::pwbs_in_t  in_item,
  output logic                busy,
  output logic                q_valid,
  output logic                q_op,
  output logic [IDX_W-1:0]    q_idx,
  output logic [31:0]         q_time,
  output logic [15:0]         q_len,
  input  logic                q_pop
);
  import pwbs_pkg::*;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      t;
    logic [15:0]      len;
  } q_entry_t;

  q_entry_t   slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push;
  q_entry_t   incoming;

  // nothing is taken while in reset
  assign busy = rst || (count == 2'd2);
  assign push = start && !busy;
  assign q_valid = (count != 2'd0);

  always_comb begin
    incoming.op  = in_item.opcode;
    incoming.idx = in_item.message_type[IDX_W-1:0];
    incoming.t   = in_item.timestamp;
    incoming.len = in_item.payload_length;
  end

  assign q_op   = slot[rd_ptr].op;
  assign q_idx  = slot[rd_ptr].idx;
  assign q_time = slot[rd_ptr].t;
  assign q_len  = slot[rd_ptr].len;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== src/pwbs_div.sv =====
// restoring divider, one quotient bit per cycle
module pwbs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);

  logic [5:0]  cnt;
  logic        run;
  logic [31:0] rem;
  logic [47:0] q;
  logic [31:0] dsr;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem, q[47]};
  assign diff    = shifted - {1'b0, dsr};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (go) begin
      q   <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (run) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        q   <= {q[46:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        q   <= {q[46:0], 1'b0};
      end
    end
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 6'd47;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/pwbs_back.sv =====
// clear sweep, table read-modify-write, then the rate division when the type has seconds
module pwbs_back #(
  parameter int IDX_W = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          budget,
  input  logic                 q_valid,
  input  logic                 q_op,
  input  logic [IDX_W-1:0]     q_idx,
  input  logic [31:0]          q_time,
  input  logic [15:0]          q_len,
  output logic                 q_pop,
  output logic                 done,
  output pwbs_pkg::pwbs_out_t  result
);
  import pwbs_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_UPD   = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t        state;
  logic [IDX_W:0] clr_cnt;
  logic          op;
  logic [IDX_W-1:0] idx;
  logic [31:0]   t;
  logic [15:0]   len;
  logic          acc;
  pwbs_entry_t   ent;

  logic          we;
  logic [IDX_W-1:0] waddr;
  pwbs_entry_t   wdata, rdata;
  logic [IDX_W-1:0] raddr;

  pwbs_entry_t   upd;
  logic          upd_acc;
  logic [15:0]   fill0;
  logic [17:0]   sum;

  logic          div_go, div_done;
  logic [47:0]   quo;

  pwbs_ram #(.WIDTH(ENTRY_W), .DEPTH(TYPE_COUNT)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  pwbs_div u_div (
    .clk(clk), .rst(rst), .go(div_go),
    .dividend({ent.msg_cnt, 16'h0000}), .divisor(ent.sec_cnt),
    .done(div_done), .quotient(quo)
  );

  // row of the held item, read during S_READ and valid in S_UPD
  assign raddr = idx;
  assign q_pop = (state == S_IDLE) && q_valid;

  always_comb begin
    upd   = rdata;
    fill0 = (op == OP_MESSAGE && rdata.msg_cnt != 32'd0 && rdata.last_time != t) ?
            16'd0 : rdata.fill;
    upd.fill = fill0;
    sum = {2'b0, fill0} + {1'b0, HEADER_BYTES} + {2'b0, len};
    upd_acc = 1'b0;
    if (op == OP_MESSAGE) begin
      if (sum <= {2'b0, budget}) begin
        upd_acc = 1'b1;
        upd.last_time = t;
        if (fill0 == 16'd0 && rdata.sec_cnt != 32'hFFFF_FFFF) begin
          upd.sec_cnt = rdata.sec_cnt + 32'd1;
        end
        upd.fill = sum[15:0];
        if (rdata.msg_cnt != 32'hFFFF_FFFF) begin
          upd.msg_cnt = rdata.msg_cnt + 32'd1;
        end
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = upd;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt[IDX_W-1:0];
      wdata = '0;
    end else if (state == S_UPD) begin
      we = 1'b1;
    end
  end

  assign div_go = (state == S_DIV) && (ent.sec_cnt != 32'd0) && !div_done;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op  <= q_op;
      idx <= q_idx;
      t   <= q_time;
      len <= q_len;
    end
    if (state == S_UPD) begin
      ent <= upd;
      acc <= upd_acc;
    end
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (IDX_W+1)'(TYPE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE:  if (q_valid) state <= S_READ;
        S_READ:  state <= S_UPD;
        S_UPD:   state <= S_DIV;
        S_DIV: begin
          if (ent.sec_cnt == 32'd0) begin
            state <= S_OUT;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (ent.sec_cnt == 32'd0 || div_done) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      result.accepted       <= acc;
      result.fill_after     <= ent.fill;
      result.accepted_count <= ent.msg_cnt;
      result.second_count   <= ent.sec_cnt;
      result.average_rate   <= (ent.sec_cnt == 32'd0) ? 48'd0 : quo;
      result.average_valid  <= (ent.sec_cnt != 32'd0);
    end
  end

endmodule
